FILE: hw/rtl/jsu_pkg.sv
`timescale 1ns / 1ps

package jsu_pkg;

  // Decoder position within the string literal.
  typedef enum logic [2:0] {
    M_IDLE,
    M_WS,
    M_BODY,
    M_ESC,
    M_HEX1,
    M_AFTER_HIGH,
    M_AFTER_HIGH_BS,
    M_HEX2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE            = 4'd0,
    ERR_NO_QUOTE        = 4'd1,
    ERR_CONTROL_CHAR    = 4'd2,
    ERR_UNTERM_ESCAPE   = 4'd3,
    ERR_BAD_ESCAPE      = 4'd4,
    ERR_TRUNC_UNICODE   = 4'd5,
    ERR_BAD_HEX         = 4'd6,
    ERR_MISSING_LOW     = 4'd7,
    ERR_BAD_LOW         = 4'd8,
    ERR_STRAY_LOW       = 4'd9,
    ERR_UNTERM_STRING   = 4'd10
  } err_code_t;

  localparam int MaxResults = 4;
  localparam int OffsetWidth = 32;

  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChCr        = 8'h0d;
  localparam logic [7:0] ChLf        = 8'h0a;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChSlash     = 8'h2f;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChLowerN    = 8'h6e;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] ChBackspace = 8'h08;
  localparam logic [7:0] ChFormFeed  = 8'h0c;

  localparam logic [15:0] HighSurrFirst = 16'hd800;
  localparam logic [15:0] HighSurrLast  = 16'hdbff;
  localparam logic [15:0] LowSurrFirst  = 16'hdc00;
  localparam logic [15:0] LowSurrLast   = 16'hdfff;
  // 0x10000 expressed in units of 1024: added to the high surrogate bits.
  localparam logic [10:0] SuppPlaneBase = 11'd64;

  // All results caused by one input word. last_idx is the count minus one.
  typedef struct packed {
    kind_t                       kind;
    logic [1:0]                  last_idx;
    logic [MaxResults-1:0][7:0]  bytes;
    err_code_t                   code;
    logic [OffsetWidth-1:0]      offset;
  } group_t;

  // Returns {valid, value} for an ASCII hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic group_t utf8_encode(input logic [20:0] cp);
    group_t g;
    g = '0;
    g.kind = KIND_BYTE;
    g.code = ERR_NONE;
    if (cp <= 21'h7f) begin
      g.last_idx = 2'd0;
      g.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7ff) begin
      g.last_idx = 2'd1;
      g.bytes[0] = {3'b110, cp[10:6]};
      g.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hffff) begin
      g.last_idx = 2'd2;
      g.bytes[0] = {4'b1110, cp[15:12]};
      g.bytes[1] = {2'b10, cp[11:6]};
      g.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      g.last_idx = 2'd3;
      g.bytes[0] = {5'b11110, cp[20:18]};
      g.bytes[1] = {2'b10, cp[17:12]};
      g.bytes[2] = {2'b10, cp[11:6]};
      g.bytes[3] = {2'b10, cp[5:0]};
    end
    return g;
  endfunction

endpackage

FILE: hw/rtl/jsu_decode.sv
`timescale 1ns / 1ps

module jsu_decode #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             string_start,
  input  logic             end_of_text,
  output logic             grp_valid,
  output jsu_pkg::group_t  grp
);

  import jsu_pkg::*;

  localparam int PW = POSITION_WIDTH;

  mode_t           mode, mode_next;
  logic [15:0]     acc, acc_next;
  logic [9:0]      hi, hi_next;
  logic [1:0]      cnt, cnt_next;
  logic [PW-1:0]   pos, pos_next;
  logic [PW-1:0]   qs, qs_next;
  logic            bad, bad_next;
  logic [PW-1:0]   boff, boff_next;

  mode_t           m;
  logic [1:0]      cnt_e;
  logic            bad_e;
  logic [PW-1:0]   after, pos_prev;
  logic [4:0]      hd;
  logic [15:0]     acc_new;
  logic            bad_new;
  logic [PW-1:0]   boff_new;

  logic            do_err, do_close, do_one, do_cp;
  err_code_t       ecode;
  logic [PW-1:0]   eoff;
  logic [7:0]      one_b;
  logic [20:0]     cp;
  logic [PW+OffsetWidth-1:0] eoff_ext;

  assign after    = pos + 1'b1;
  assign pos_prev = pos - 1'b1;
  assign hd       = hex_digit(data_byte);

  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    hi_next   = hi;
    cnt_next  = cnt;
    pos_next  = pos;
    qs_next   = qs;
    bad_next  = bad;
    boff_next = boff;
    do_err    = 1'b0;
    do_close  = 1'b0;
    do_one    = 1'b0;
    do_cp     = 1'b0;
    ecode     = ERR_NONE;
    eoff      = '0;
    one_b     = '0;
    cp        = '0;
    acc_new   = acc;
    bad_new   = bad;
    boff_new  = boff;

    m     = mode;
    cnt_e = cnt;
    bad_e = bad;
    if (string_start) begin
      m     = M_WS;
      cnt_e = 2'd0;
      bad_e = 1'b0;
    end
    cnt_next = cnt_e;
    bad_next = bad_e;

    if (end_of_text) begin
      case (m)
        M_WS: begin
          do_err = 1'b1; ecode = ERR_NO_QUOTE; eoff = pos;
        end
        M_BODY: begin
          do_err = 1'b1; ecode = ERR_UNTERM_STRING; eoff = pos;
        end
        M_ESC: begin
          do_err = 1'b1; ecode = ERR_UNTERM_ESCAPE; eoff = pos;
        end
        M_HEX1, M_HEX2: begin
          do_err = 1'b1; ecode = ERR_TRUNC_UNICODE; eoff = qs;
        end
        M_AFTER_HIGH: begin
          do_err = 1'b1; ecode = ERR_MISSING_LOW; eoff = pos;
        end
        M_AFTER_HIGH_BS: begin
          do_err = 1'b1; ecode = ERR_MISSING_LOW; eoff = pos_prev;
        end
        default: begin
        end
      endcase
      mode_next = M_IDLE;
      pos_next  = '0;
    end else begin
      pos_next = after;
      case (m)
        M_WS: begin
          if (data_byte == ChSpace || data_byte == ChTab ||
              data_byte == ChCr || data_byte == ChLf) begin
            mode_next = M_WS;
          end else if (data_byte == ChQuote) begin
            mode_next = M_BODY;
          end else begin
            do_err = 1'b1; ecode = ERR_NO_QUOTE; eoff = pos;
          end
        end
        M_BODY: begin
          mode_next = M_BODY;
          if (data_byte == ChQuote) begin
            do_close  = 1'b1;
            mode_next = M_IDLE;
          end else if (data_byte < ChSpace) begin
            do_err = 1'b1; ecode = ERR_CONTROL_CHAR; eoff = after;
          end else if (data_byte != ChBackslash) begin
            do_one = 1'b1; one_b = data_byte;
          end else begin
            mode_next = M_ESC;
          end
        end
        M_ESC: begin
          mode_next = M_BODY;
          case (data_byte)
            ChQuote:     begin do_one = 1'b1; one_b = ChQuote;     end
            ChBackslash: begin do_one = 1'b1; one_b = ChBackslash; end
            ChSlash:     begin do_one = 1'b1; one_b = ChSlash;     end
            ChLowerB:    begin do_one = 1'b1; one_b = ChBackspace; end
            ChLowerF:    begin do_one = 1'b1; one_b = ChFormFeed;  end
            ChLowerN:    begin do_one = 1'b1; one_b = ChLf;        end
            ChLowerR:    begin do_one = 1'b1; one_b = ChCr;        end
            ChLowerT:    begin do_one = 1'b1; one_b = ChTab;       end
            ChLowerU: begin
              mode_next = M_HEX1;
              qs_next   = after;
              acc_next  = '0;
              cnt_next  = 2'd0;
              bad_next  = 1'b0;
              boff_next = '0;
            end
            default: begin
              do_err = 1'b1; ecode = ERR_BAD_ESCAPE; eoff = after;
            end
          endcase
        end
        M_HEX1, M_HEX2: begin
          acc_new  = hd[4] ? {acc[11:0], hd[3:0]} : acc;
          bad_new  = bad_e;
          boff_new = boff;
          // Only the first bad digit of a quad is remembered.
          if (!hd[4] && !bad_e) begin
            bad_new  = 1'b1;
            boff_new = pos;
          end
          acc_next  = acc_new;
          bad_next  = bad_new;
          boff_next = boff_new;
          if (cnt_e == 2'd3) begin
            cnt_next = 2'd0;
            if (bad_new) begin
              do_err = 1'b1; ecode = ERR_BAD_HEX; eoff = boff_new;
            end else if (m == M_HEX1) begin
              if (acc_new >= HighSurrFirst && acc_new <= HighSurrLast) begin
                hi_next   = acc_new[9:0];
                mode_next = M_AFTER_HIGH;
              end else if (acc_new >= LowSurrFirst && acc_new <= LowSurrLast) begin
                do_err = 1'b1; ecode = ERR_STRAY_LOW; eoff = after;
              end else begin
                do_cp     = 1'b1;
                cp        = {5'd0, acc_new};
                mode_next = M_BODY;
              end
            end else begin
              if (acc_new < LowSurrFirst || acc_new > LowSurrLast) begin
                do_err = 1'b1; ecode = ERR_BAD_LOW; eoff = after;
              end else begin
                do_cp     = 1'b1;
                cp        = {11'({1'b0, hi} + SuppPlaneBase), acc_new[9:0]};
                mode_next = M_BODY;
              end
            end
          end else begin
            cnt_next  = cnt_e + 2'd1;
            mode_next = m;
          end
        end
        M_AFTER_HIGH: begin
          if (data_byte == ChBackslash) begin
            mode_next = M_AFTER_HIGH_BS;
          end else begin
            do_err = 1'b1; ecode = ERR_MISSING_LOW; eoff = pos;
          end
        end
        M_AFTER_HIGH_BS: begin
          if (data_byte == ChLowerU) begin
            mode_next = M_HEX2;
            qs_next   = after;
            acc_next  = '0;
            cnt_next  = 2'd0;
            bad_next  = 1'b0;
            boff_next = '0;
          end else begin
            do_err = 1'b1; ecode = ERR_MISSING_LOW; eoff = pos_prev;
          end
        end
        default: begin
          mode_next = m;
        end
      endcase
    end

    if (do_err) begin
      mode_next = M_IDLE;
    end
  end

  // Offsets are reported as the low 32 bits of the position.
  assign eoff_ext = {{OffsetWidth{1'b0}}, eoff};

  always_comb begin
    grp      = '0;
    grp.kind = KIND_BYTE;
    grp.code = ERR_NONE;
    if (do_err) begin
      grp.kind   = KIND_ERROR;
      grp.code   = ecode;
      grp.offset = eoff_ext[OffsetWidth-1:0];
    end else if (do_close) begin
      grp.kind = KIND_CLOSE;
    end else if (do_one) begin
      grp.bytes[0] = one_b;
    end else if (do_cp) begin
      grp = utf8_encode(cp);
    end
  end

  assign grp_valid = accept && (do_err || do_close || do_one || do_cp);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      acc  <= '0;
      hi   <= '0;
      cnt  <= '0;
      pos  <= '0;
      qs   <= '0;
      bad  <= 1'b0;
      boff <= '0;
    end else if (accept) begin
      mode <= mode_next;
      acc  <= acc_next;
      hi   <= hi_next;
      cnt  <= cnt_next;
      pos  <= pos_next;
      qs   <= qs_next;
      bad  <= bad_next;
      boff <= boff_next;
    end
  end

endmodule

FILE: hw/rtl/jsu_outq.sv
`timescale 1ns / 1ps

module jsu_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  jsu_pkg::group_t  wr_grp,
  output logic             can_accept,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic [1:0]       kind,
  output logic [3:0]       error_code,
  output logic [31:0]      error_offset,
  output logic             last_of_run
);

  import jsu_pkg::*;

  group_t      head, pend;
  logic        head_valid, pend_valid;
  logic [1:0]  idx;
  logic        last, pop, adv, load_new, load_pend;

  assign last      = (idx == head.last_idx);
  assign pop       = head_valid && out_ready && last;
  assign adv       = head_valid && out_ready && !last;
  // A new word is written only while the pending slot is empty.
  assign load_new  = wr && (!head_valid || pop);
  assign load_pend = !wr && pop && pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      pend_valid <= 1'b0;
      idx        <= '0;
    end else begin
      if (load_new || load_pend) begin
        head_valid <= 1'b1;
        idx        <= '0;
      end else if (pop) begin
        head_valid <= 1'b0;
      end else if (adv) begin
        idx <= idx + 2'd1;
      end
      if (wr && !load_new) begin
        pend_valid <= 1'b1;
      end else if (load_pend) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_new) begin
      head <= wr_grp;
    end else if (load_pend) begin
      head <= pend;
    end
    if (wr && !load_new) begin
      pend <= wr_grp;
    end
  end

  assign can_accept   = !pend_valid;
  assign out_valid    = head_valid;
  assign out_byte     = (head.kind == KIND_BYTE) ? head.bytes[idx] : 8'd0;
  assign kind         = head.kind;
  assign error_code   = head.code;
  assign error_offset = head.offset;
  assign last_of_run  = last;

endmodule

FILE: hw/rtl/json_string_unescape_utf8.sv
`timescale 1ns / 1ps
// Channel | Handshake          | Payload
// --------+--------------------+------------------------------------------------
// in      | in_valid/in_ready  | data_byte, string_start, end_of_text
// out     | out_valid/out_ready| out_byte, kind, error_code, error_offset,
//         |                    | last_of_run
//
// An input word is decoded in the cycle it is accepted; its results (none to four)
// go to a two-entry queue and leave it one per cycle while out_ready is high. Input
// is taken every cycle while the pending slot is free, so one-result words run at
// one word per cycle while out_ready stays high; a word giving N results holds the
// queue head until all N are taken. Reset is synchronous: it returns the decoder to
// idle with the text position at zero and empties the queue. A stalled output fills
// the pending slot, after which in_ready drops until the head is delivered.

module json_string_unescape_utf8 #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        string_start,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  kind,
  output logic [3:0]  error_code,
  output logic [31:0] error_offset,
  output logic        last_of_run
);

  import jsu_pkg::*;

  logic    accept;
  logic    grp_valid;
  group_t  grp;

  assign accept = in_valid && in_ready;

  jsu_decode #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_decode (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .string_start (string_start),
    .end_of_text  (end_of_text),
    .grp_valid    (grp_valid),
    .grp          (grp)
  );

  jsu_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .wr           (grp_valid),
    .wr_grp       (grp),
    .can_accept   (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .kind         (kind),
    .error_code   (error_code),
    .error_offset (error_offset),
    .last_of_run  (last_of_run)
  );

endmodule

FILE: hw/rtl/jsu_checker.sv
`timescale 1ns / 1ps

module jsu_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic [1:0]  kind,
  input logic [3:0]  error_code,
  input logic        last_of_run
);

  import jsu_pkg::*;

  // A word stays on the output until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped before it was taken");

  // Close and error results always end the run of their input word.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_BYTE |-> last_of_run)
    else $error("close or error result not last of its run");

  // An error code is present exactly on error results.
  a_code_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
    else $error("error code does not match result kind");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_BYTE |-> out_byte == 8'd0)
    else $error("nonzero byte on a close or error result");

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .kind        (kind),
  .error_code  (error_code),
  .last_of_run (last_of_run)
);

FILE: verif/json_string_unescape_utf8_test.sv
`timescale 1ns / 1ps

import jsu_pkg::*;

typedef struct {
  logic [7:0]  out_byte;
  kind_t       kind;
  err_code_t   code;
  logic [31:0] offset;
  logic        last;
} decoded_t;

function automatic int hex_nibble(logic [7:0] c);
  if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
  if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
  if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
  return -1;
endfunction

class unescape_scoreboard;
  mode_t       mode;
  logic [15:0] quad_value;
  logic [9:0]  high_bits;
  logic [1:0]  digits_in;
  logic [31:0] text_pos;
  logic [31:0] quad_pos;
  logic [31:0] bad_pos;
  bit          bad_seen;
  decoded_t    burst[$];
  decoded_t    decoded_due[$];
  int          mismatches;
  int          words;
  int          n_bytes;
  int          n_closes;
  int          n_errors;
  bit [15:0]   codes_seen;

  function new();
    mode = M_IDLE;
    quad_value = '0;
    high_bits = '0;
    digits_in = '0;
    text_pos = '0;
    quad_pos = '0;
    bad_pos = '0;
    bad_seen = 1'b0;
    mismatches = 0;
    words = 0;
    n_bytes = 0;
    n_closes = 0;
    n_errors = 0;
    codes_seen = '0;
  endfunction

  function int due_count();
    return decoded_due.size();
  endfunction

  function void put(logic [7:0] b, kind_t k, err_code_t c, logic [31:0] off);
    decoded_t r;
    if (burst.size() >= MaxResults) return;
    r.out_byte = b;
    r.kind = k;
    r.code = c;
    r.offset = off;
    r.last = 1'b0;
    burst.insert(burst.size(), r);
  endfunction

  function void fail(err_code_t c, logic [31:0] off);
    put(8'h00, KIND_ERROR, c, off);
    mode = M_IDLE;
  endfunction

  function void emit_utf8(logic [20:0] cp);
    if (cp <= 21'h7f) begin
      put(cp[7:0], KIND_BYTE, ERR_NONE, '0);
    end else if (cp <= 21'h7ff) begin
      put(8'h00 | 8'hc0 | 8'(cp >> 6), KIND_BYTE, ERR_NONE, '0);
      put(8'h80 | 8'(cp & 21'h3f), KIND_BYTE, ERR_NONE, '0);
    end else if (cp <= 21'hffff) begin
      put(8'he0 | 8'(cp >> 12), KIND_BYTE, ERR_NONE, '0);
      put(8'h80 | 8'((cp >> 6) & 21'h3f), KIND_BYTE, ERR_NONE, '0);
      put(8'h80 | 8'(cp & 21'h3f), KIND_BYTE, ERR_NONE, '0);
    end else begin
      put(8'hf0 | 8'((cp >> 18) & 21'h07), KIND_BYTE, ERR_NONE, '0);
      put(8'h80 | 8'((cp >> 12) & 21'h3f), KIND_BYTE, ERR_NONE, '0);
      put(8'h80 | 8'((cp >> 6) & 21'h3f), KIND_BYTE, ERR_NONE, '0);
      put(8'h80 | 8'(cp & 21'h3f), KIND_BYTE, ERR_NONE, '0);
    end
  endfunction

  function void open_quad(mode_t m);
    mode = m;
    quad_pos = text_pos + 1;
    quad_value = '0;
    digits_in = '0;
    bad_seen = 1'b0;
    bad_pos = '0;
  endfunction

  // Works out the results of one accepted input word and queues them.
  function void decode_word(logic [7:0] data, logic start, logic eot);
    logic [31:0] after;
    int h;
    burst.delete();
    words++;
    after = text_pos + 1;
    if (start) begin
      mode = M_WS;
      bad_seen = 1'b0;
      digits_in = '0;
    end
    if (eot) begin
      case (mode)
        M_WS: fail(ERR_NO_QUOTE, text_pos);
        M_BODY: fail(ERR_UNTERM_STRING, text_pos);
        M_ESC: fail(ERR_UNTERM_ESCAPE, text_pos);
        M_HEX1, M_HEX2: fail(ERR_TRUNC_UNICODE, quad_pos);
        M_AFTER_HIGH: fail(ERR_MISSING_LOW, text_pos);
        M_AFTER_HIGH_BS: fail(ERR_MISSING_LOW, text_pos - 1);
        default: ;
      endcase
      mode = M_IDLE;
      text_pos = '0;
    end else begin
      case (mode)
        M_WS: begin
          if (data == ChQuote) begin
            mode = M_BODY;
          end else if (!(data inside {ChSpace, ChTab, ChCr, ChLf})) begin
            fail(ERR_NO_QUOTE, text_pos);
          end
        end
        M_BODY: begin
          if (data == ChQuote) begin
            put(8'h00, KIND_CLOSE, ERR_NONE, '0);
            mode = M_IDLE;
          end else if (data < ChSpace) begin
            fail(ERR_CONTROL_CHAR, after);
          end else if (data == ChBackslash) begin
            mode = M_ESC;
          end else begin
            put(data, KIND_BYTE, ERR_NONE, '0);
          end
        end
        M_ESC: begin
          mode = M_BODY;
          case (data)
            ChQuote, ChBackslash, ChSlash: put(data, KIND_BYTE, ERR_NONE, '0);
            ChLowerB: put(ChBackspace, KIND_BYTE, ERR_NONE, '0);
            ChLowerF: put(ChFormFeed, KIND_BYTE, ERR_NONE, '0);
            ChLowerN: put(ChLf, KIND_BYTE, ERR_NONE, '0);
            ChLowerR: put(ChCr, KIND_BYTE, ERR_NONE, '0);
            ChLowerT: put(ChTab, KIND_BYTE, ERR_NONE, '0);
            ChLowerU: open_quad(M_HEX1);
            default: fail(ERR_BAD_ESCAPE, after);
          endcase
        end
        M_HEX1, M_HEX2: begin
          h = hex_nibble(data);
          // A bad digit is only reported once all four bytes of the quad are in.
          if (h < 0) begin
            if (!bad_seen) begin
              bad_seen = 1'b1;
              bad_pos = text_pos;
            end
          end else begin
            quad_value = {quad_value[11:0], 4'(h)};
          end
          if (digits_in == 2'd3) begin
            digits_in = '0;
            if (bad_seen) begin
              fail(ERR_BAD_HEX, bad_pos);
            end else if (mode == M_HEX1) begin
              if (quad_value inside {[HighSurrFirst:HighSurrLast]}) begin
                high_bits = quad_value[9:0];
                mode = M_AFTER_HIGH;
              end else if (quad_value inside {[LowSurrFirst:LowSurrLast]}) begin
                fail(ERR_STRAY_LOW, after);
              end else begin
                emit_utf8({5'd0, quad_value});
                mode = M_BODY;
              end
            end else if (!(quad_value inside {[LowSurrFirst:LowSurrLast]})) begin
              fail(ERR_BAD_LOW, after);
            end else begin
              emit_utf8(21'h10000 + {high_bits, quad_value[9:0]});
              mode = M_BODY;
            end
          end else begin
            digits_in++;
          end
        end
        M_AFTER_HIGH: begin
          if (data == ChBackslash) mode = M_AFTER_HIGH_BS;
          else fail(ERR_MISSING_LOW, text_pos);
        end
        M_AFTER_HIGH_BS: begin
          if (data == ChLowerU) open_quad(M_HEX2);
          else fail(ERR_MISSING_LOW, text_pos - 1);
        end
        default: ;
      endcase
      text_pos = after;
    end
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) decoded_due.insert(decoded_due.size(), burst[i]);
  endfunction

  function void check_result(logic [7:0] got_byte, logic [1:0] got_kind,
                             logic [3:0] got_code, logic [31:0] got_offset,
                             logic got_last);
    decoded_t want;
    if (decoded_due.size() == 0) begin
      $error("result with nothing outstanding: kind %0d byte %h code %0d",
             got_kind, got_byte, got_code);
      mismatches++;
      return;
    end
    want = decoded_due.pop_front();
    if (got_byte !== want.out_byte) begin
      $error("out_byte: expected %h, got %h", want.out_byte, got_byte);
      mismatches++;
    end
    if (got_kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got_kind);
      mismatches++;
    end
    if (got_code !== want.code) begin
      $error("error_code: expected %0d, got %0d", want.code, got_code);
      mismatches++;
    end
    if (got_offset !== want.offset) begin
      $error("error_offset: expected %0d, got %0d", want.offset, got_offset);
      mismatches++;
    end
    if (got_last !== want.last) begin
      $error("last_of_run: expected %0b, got %0b", want.last, got_last);
      mismatches++;
    end
    case (want.kind)
      KIND_BYTE: n_bytes++;
      KIND_CLOSE: n_closes++;
      default: begin
        n_errors++;
        codes_seen[want.code] = 1'b1;
      end
    endcase
  endfunction
endclass

module json_string_unescape_utf8_test;

  localparam int CycleLimit = 200000;

  typedef struct {
    logic [7:0] data;
    logic       start;
    logic       eot;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        string_start = 1'b0;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic [1:0]  kind;
  logic [3:0]  error_code;
  logic [31:0] error_offset;
  logic        last_of_run;

  unescape_scoreboard board = new();
  word_t text_words[$];
  int    live_words = 0;
  int    cycles = 0;
  int    out_hold = 0;
  bit    calm = 1'b0;

  json_string_unescape_utf8 dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .string_start(string_start),
    .end_of_text(end_of_text),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .kind(kind),
    .error_code(error_code),
    .error_offset(error_offset),
    .last_of_run(last_of_run)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int idle_draw();
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else if (out_valid && out_ready) begin
      board.check_result(out_byte, kind, error_code, error_offset, last_of_run);
      out_hold = idle_draw();
      out_ready <= (out_hold == 0);
    end else if (out_hold > 0) begin
      out_hold--;
      out_ready <= (out_hold == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void add_word(logic [7:0] d, logic e = 1'b0);
    word_t w;
    w = '{data: d, start: 1'b0, eot: e};
    text_words.insert(text_words.size(), w);
    live_words++;
  endfunction

  // Bytes the decoder should ignore or that merely follow a string.
  function automatic void add_noise();
    word_t w;
    repeat ($urandom_range(0, 2)) begin
      w = '{data: 8'($urandom()), start: 1'b0, eot: 1'b0};
      text_words.insert(text_words.size(), w);
    end
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n - 4'd10);
  endfunction

  function automatic void add_unicode(logic [15:0] v);
    add_word(ChBackslash);
    add_word(ChLowerU);
    for (int i = 3; i >= 0; i--) add_word(hex_char(v[4*i +: 4]));
  endfunction

  function automatic logic [7:0] ws_char();
    case ($urandom_range(0, 3))
      0: return ChSpace;
      1: return ChTab;
      2: return ChCr;
      default: return ChLf;
    endcase
  endfunction

  function automatic bit escape_known(logic [7:0] c);
    return c inside {ChQuote, ChBackslash, ChSlash, ChLowerB, ChLowerF, ChLowerN,
                     ChLowerR, ChLowerT, ChLowerU};
  endfunction

  // Appends one piece of string body; 0 to 3 are well formed, the rest broken.
  function automatic int add_piece(int sel);
    int first_n;
    int i;
    logic [15:0] v;
    logic [15:0] hi;
    logic [7:0] c;
    logic [3:0] spoil;
    first_n = text_words.size();
    v = 16'($urandom());
    hi = {6'b110110, 10'($urandom())};
    case (sel)
      0: begin
        do c = 8'($urandom_range(32, 255)); while (c == ChQuote || c == ChBackslash);
        add_word(c);
      end
      1: begin
        do c = 8'($urandom()); while (!escape_known(c) || c == ChLowerU);
        add_word(ChBackslash);
        add_word(c);
      end
      2: begin
        case ($urandom_range(0, 2))
          0: v = 16'($urandom_range(0, 16'h7f));
          1: v = 16'($urandom_range(16'h80, 16'h7ff));
          default: if (v[15:11] == 5'b11011) v[13] = 1'b1;
        endcase
        add_unicode(v);
      end
      3: begin
        add_unicode(hi);
        add_unicode({6'b110111, v[9:0]});
      end
      4: add_word(8'($urandom_range(0, 31)));
      5: begin
        do c = 8'($urandom()); while (escape_known(c));
        add_word(ChBackslash);
        add_word(c);
      end
      6: begin
        spoil = 4'($urandom_range(1, 15));
        add_word(ChBackslash);
        add_word(ChLowerU);
        for (i = 3; i >= 0; i--) begin
          if (spoil[i]) begin
            do c = 8'($urandom()); while (hex_nibble(c) >= 0);
            add_word(c);
          end else begin
            add_word(hex_char(v[4*i +: 4]));
          end
        end
      end
      7: add_unicode({6'b110111, v[9:0]});
      8: begin
        add_unicode(hi);
        do c = 8'($urandom()); while (c == ChBackslash);
        add_word(c);
      end
      9: begin
        add_unicode(hi);
        add_word(ChBackslash);
        do c = 8'($urandom()); while (c == ChLowerU);
        add_word(c);
      end
      default: begin
        add_unicode(hi);
        if (v[15:10] == 6'b110111) v[15] = 1'b0;
        add_unicode(v);
      end
    endcase
    return text_words.size() - first_n;
  endfunction

  function automatic void build_string();
    int start_at;
    int n;
    logic [7:0] c;
    start_at = text_words.size();
    repeat ($urandom_range(0, 2)) add_word(ws_char());
    case ($urandom_range(0, 19))
      0: add_word(8'($urandom()), 1'b1);
      1: begin
        do c = 8'($urandom()); while (c == ChQuote || c inside {ChSpace, ChTab, ChCr, ChLf});
        add_word(c);
      end
      default: begin
        add_word(ChQuote);
        repeat ($urandom_range(0, 6)) void'(add_piece($urandom_range(0, 3)));
        case ($urandom_range(0, 19))
          12, 13: void'(add_piece($urandom_range(4, 10)));
          14: add_word(8'($urandom()), 1'b1);
          15, 16: begin
            // Text ends partway through an escape, a quad or a surrogate pair.
            case ($urandom_range(0, 3))
              0: n = add_piece(1);
              1: n = add_piece(2);
              2: n = add_piece(3);
              default: n = add_piece(6);
            endcase
            repeat ($urandom_range(1, n - 1)) void'(text_words.pop_back());
            add_word(8'($urandom()), 1'b1);
          end
          // Left open: the next string start abandons it.
          17: ;
          18, 19: begin
            add_word(ChQuote);
            add_word(8'($urandom()), 1'b1);
          end
          default: add_word(ChQuote);
        endcase
      end
    endcase
    text_words[start_at].start = 1'b1;
    add_noise();
  endfunction

  task automatic send_words();
    word_t w;
    int gap;
    while (text_words.size() > 0) begin
      w = text_words.pop_front();
      gap = idle_draw();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      data_byte <= w.data;
      string_start <= w.start;
      end_of_text <= w.eot;
      do @(posedge clk); while (!in_ready);
      board.decode_word(w.data, w.start, w.eot);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.due_count() > 0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Leading space, top byte, the largest code point, a simple escape, close.
    add_word(ChSpace);
    text_words[0].start = 1'b1;
    add_word(ChQuote);
    add_word(8'hff);
    add_unicode(16'hdbff);
    add_unicode(16'hdfff);
    add_word(ChBackslash);
    add_word(ChLowerN);
    add_word(ChQuote);
    add_word(8'h00);
    add_word(8'h00);
    text_words[text_words.size() - 1].start = 1'b1;
    add_word(8'h00, 1'b1);
    add_word(ChQuote);
    text_words[text_words.size() - 1].start = 1'b1;
    add_word(8'hff, 1'b1);
    send_words();
    drain();

    live_words = 0;
    while (live_words < 300) begin
      calm = ($urandom_range(0, 3) == 0);
      build_string();
      send_words();
      if ($urandom_range(0, 9) == 0) drain();
    end
    calm = 1'b0;
    drain();
    repeat (10) @(posedge clk);

    $display("Sent %0d words; checked %0d decoded bytes, %0d closed strings, %0d errors.",
             board.words, board.n_bytes, board.n_closes, board.n_errors);
    $display("Error codes reported (one bit per code): %b", board.codes_seen[10:1]);
    if (board.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
